// ===== rtl/prh_pkg.sv =====
// Package for the packet reorder holder: widths, action codes, queue control.
// No dependencies; imported by every module of the block.
`default_nettype none
package prh_pkg;
    localparam int KEY_W           = 32;
    localparam int TAG_IN_W        = 16;
    localparam int RND_W           = 16;
    localparam int DIS_W           = 16;
    localparam int ACT_W           = 2;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam logic [ACT_W-1:0] ACT_NEW     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH   = 2'd2;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic insert;
        logic pop;
    } queue_op_t;
endpackage
`default_nettype wire

// ===== rtl/prh_cell.sv =====
// One cell of the sorted holding chain: a key, a tag and a valid bit.
// Depends on prh_pkg; instantiated by prh_queue.
`default_nettype none
module prh_cell #(
    parameter int TAG_WIDTH = prh_pkg::TAG_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire prh_pkg::queue_op_t      op,
    input  wire [prh_pkg::KEY_W-1:0]     new_key,
    input  wire [TAG_WIDTH-1:0]          new_tag,
    input  wire                          prev_valid,
    input  wire [prh_pkg::KEY_W-1:0]     prev_key,
    input  wire [TAG_WIDTH-1:0]          prev_tag,
    input  wire                          prev_gt,
    input  wire                          next_valid,
    input  wire [prh_pkg::KEY_W-1:0]     next_key,
    input  wire [TAG_WIDTH-1:0]          next_tag,
    output logic                         valid,
    output logic [prh_pkg::KEY_W-1:0]    key,
    output logic [TAG_WIDTH-1:0]         tag,
    output logic                         gt
);
    import prh_pkg::*;

    logic                 valid_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TAG_WIDTH-1:0] tag_reg;

    assign gt    = !valid_reg || (key_reg > new_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op.pop)
        begin
            valid_reg <= next_valid;
        end
        else if (op.insert && gt)
        begin
            valid_reg <= prev_gt ? prev_valid : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.pop)
        begin
            key_reg <= next_key;
            tag_reg <= next_tag;
        end
        else if (op.insert && gt)
        begin
            if (prev_gt)
            begin
                key_reg <= prev_key;
                tag_reg <= prev_tag;
            end
            else
            begin
                key_reg <= new_key;
                tag_reg <= new_tag;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/prh_queue.sv =====
// Chain of cells for one direction, kept sorted by key, then by age.
// Depends on prh_pkg and prh_cell.
`default_nettype none
module prh_queue #(
    parameter int QUEUE_DEPTH = prh_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = prh_pkg::TAG_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire prh_pkg::queue_op_t      op,
    input  wire [prh_pkg::KEY_W-1:0]     new_key,
    input  wire [TAG_WIDTH-1:0]          new_tag,
    output logic                         head_valid,
    output logic [prh_pkg::KEY_W-1:0]    head_key,
    output logic [TAG_WIDTH-1:0]         head_tag,
    output logic                         second_valid,
    output logic [prh_pkg::KEY_W-1:0]    second_key,
    output logic                         full
);
    import prh_pkg::*;

    logic                 c_valid [QUEUE_DEPTH];
    logic [KEY_W-1:0]     c_key   [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] c_tag   [QUEUE_DEPTH];
    logic                 c_gt    [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                 pv;
            logic [KEY_W-1:0]     pk;
            logic [TAG_WIDTH-1:0] pt;
            logic                 pg;
            logic                 nv;
            logic [KEY_W-1:0]     nk;
            logic [TAG_WIDTH-1:0] nt;
            if (i == 0)
            begin : g_first
                assign pv = 1'b0;
                assign pk = '0;
                assign pt = '0;
                assign pg = 1'b0;
            end
            else
            begin : g_mid
                assign pv = c_valid[i-1];
                assign pk = c_key[i-1];
                assign pt = c_tag[i-1];
                assign pg = c_gt[i-1];
            end
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign nv = 1'b0;
                assign nk = '0;
                assign nt = '0;
            end
            else
            begin : g_next
                assign nv = c_valid[i+1];
                assign nk = c_key[i+1];
                assign nt = c_tag[i+1];
            end
            prh_cell #(.TAG_WIDTH(TAG_WIDTH)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .new_key    (new_key),
                .new_tag    (new_tag),
                .prev_valid (pv),
                .prev_key   (pk),
                .prev_tag   (pt),
                .prev_gt    (pg),
                .next_valid (nv),
                .next_key   (nk),
                .next_tag   (nt),
                .valid      (c_valid[i]),
                .key        (c_key[i]),
                .tag        (c_tag[i]),
                .gt         (c_gt[i])
            );
        end
        if (QUEUE_DEPTH > 1)
        begin : g_second
            assign second_valid = c_valid[1];
            assign second_key   = c_key[1];
        end
        else
        begin : g_no_second
            assign second_valid = 1'b0;
            assign second_key   = '0;
        end
    endgenerate

    assign head_valid = c_valid[0];
    assign head_key   = c_key[0];
    assign head_tag   = c_tag[0];
    assign full       = c_valid[QUEUE_DEPTH-1];
endmodule
`default_nettype wire

// ===== rtl/prh_modu.sv =====
// Bit-serial restoring remainder unit: random draw modulo max delay.
// Depends on prh_pkg; instantiated by the top level.
`default_nettype none
module prh_modu (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [prh_pkg::RND_W-1:0]     dividend,
    input  wire [prh_pkg::DIS_W-1:0]     divisor,
    output logic                         done,
    output logic [prh_pkg::DIS_W-1:0]    remainder
);
    import prh_pkg::*;

    localparam int CNT_W = $clog2(RND_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RND_W-1:0] dvd_reg;
    logic [DIS_W:0]   rem_reg;
    logic [DIS_W-1:0] dsr_reg;
    logic [DIS_W:0]   trial;

    assign trial     = {rem_reg[DIS_W-1:0], dvd_reg[RND_W-1]};
    assign done      = done_reg;
    assign remainder = rem_reg[DIS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= (divisor == '0) ? DIS_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, dsr_reg}) ? trial - {1'b0, dsr_reg} : trial;
        end
    end

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < {1'b0, dsr_reg})
        else $error("remainder not below divisor");
endmodule
`default_nettype wire

// ===== rtl/packet_reorder_holder_core.sv =====
// Top level of the packet reorder holder: control, counters, output register.
// Depends on prh_pkg, prh_queue (with prh_cell) and prh_modu.
//
//  channel | signals                                         | handshake
//  input   | action direction packet_tag hold random_value  | in_valid / in_stall
//  output  | out_tag out_direction last_in_run               | out_valid / out_stall
//  config  | cfg_data (disorder limit)                       | cfg_we
//
// A held packet goes through accept, a remainder step per bit of random_value, key, insert.
// A passed packet goes through accept and S_PASS; release and flush drain chain 0, then chain 1,
// paced by one pop of a chain per cycle while out_stall does not hold the output register.
// Reset empties both chains, clears counters and sets the disorder limit to 1.
// out_stall holds the output register and the drain waits on it.
`default_nettype none
module packet_reorder_holder_core #(
    parameter int QUEUE_DEPTH = prh_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = prh_pkg::TAG_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [prh_pkg::ACT_W-1:0]     action,
    input  wire                          direction,
    input  wire [prh_pkg::TAG_IN_W-1:0]  packet_tag,
    input  wire                          hold,
    input  wire [prh_pkg::RND_W-1:0]     random_value,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [prh_pkg::TAG_IN_W-1:0] out_tag,
    output logic                         out_direction,
    output logic                         last_in_run,
    input  wire                          cfg_we,
    input  wire [prh_pkg::DIS_W-1:0]     cfg_data
);
    import prh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_INS,
        S_PASS,
        S_DRAIN0,
        S_DRAIN1
    } state_t;

    state_t               state_reg;
    logic [KEY_W-1:0]     cnt_reg [2];
    logic [DIS_W-1:0]     dis_limit_reg;
    logic                 dir_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 all_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 out_valid_reg;
    logic [TAG_IN_W-1:0]  out_tag_reg;
    logic                 out_direction_reg;
    logic                 last_in_run_reg;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [DIS_W-1:0]     div_rem;
    logic [KEY_W:0]       key_sum;
    queue_op_t            qop     [2];
    logic                 hv      [2];
    logic [KEY_W-1:0]     hkey    [2];
    logic [TAG_WIDTH-1:0] htag    [2];
    logic                 sv      [2];
    logic [KEY_W-1:0]     skey    [2];
    logic                 qfull   [2];
    logic                 head_due[2];
    logic                 next_due[2];

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_PASS && out_free) || qop[0].pop || qop[1].pop;
    assign div_start = accept && (action == ACT_NEW) && hold && !qfull[direction];
    assign key_sum   = {1'b0, cnt_reg[dir_reg]} + (KEY_W + 1)'(div_rem) + (KEY_W + 1)'(1);

    genvar d;
    generate
        for (d = 0; d < 2; d++)
        begin : g_dir
            assign head_due[d] = hv[d] && (all_reg || hkey[d] <= cnt_reg[d]);
            assign next_due[d] = sv[d] && (all_reg || skey[d] <= cnt_reg[d]);
            assign qop[d] = '{
                insert: (state_reg == S_INS) && (dir_reg == 1'(d)),
                pop:    out_free && head_due[d] &&
                        ((d == 0) ? (state_reg == S_DRAIN0) : (state_reg == S_DRAIN1))
            };
            prh_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)) u_queue (
                .clk          (clk),
                .rst_n        (rst_n),
                .op           (qop[d]),
                .new_key      (key_reg),
                .new_tag      (tag_reg),
                .head_valid   (hv[d]),
                .head_key     (hkey[d]),
                .head_tag     (htag[d]),
                .second_valid (sv[d]),
                .second_key   (skey[d]),
                .full         (qfull[d])
            );
        end
    endgenerate

    prh_modu u_modu (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (random_value),
        .divisor   (dis_limit_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dis_limit_reg <= DIS_W'(1);
        end
        else if (cfg_we)
        begin
            dis_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg[0]        <= '0;
            cnt_reg[1]        <= '0;
            out_valid_reg     <= 1'b0;
            out_tag_reg       <= '0;
            out_direction_reg <= 1'b0;
            last_in_run_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_PASS && out_free)
            begin
                out_tag_reg       <= TAG_IN_W'(tag_reg);
                out_direction_reg <= dir_reg;
                last_in_run_reg   <= 1'b1;
            end
            else if (qop[0].pop)
            begin
                out_tag_reg       <= TAG_IN_W'(htag[0]);
                out_direction_reg <= 1'b0;
                last_in_run_reg   <= !next_due[0] && !head_due[1];
            end
            else if (qop[1].pop)
            begin
                out_tag_reg       <= TAG_IN_W'(htag[1]);
                out_direction_reg <= 1'b1;
                last_in_run_reg   <= !next_due[1];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (action == ACT_NEW)
                        begin
                            if (cnt_reg[direction] != KEY_MAX)
                            begin
                                cnt_reg[direction] <= cnt_reg[direction] + 1'b1;
                            end
                            state_reg <= div_start ? S_DIV : S_PASS;
                        end
                        else if (action == ACT_RELEASE || action == ACT_FLUSH)
                        begin
                            state_reg <= S_DRAIN0;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_INS;
                    end
                end
                S_INS:
                begin
                    state_reg <= S_IDLE;
                end
                S_PASS:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DRAIN0:
                begin
                    if (!head_due[0])
                    begin
                        state_reg <= S_DRAIN1;
                    end
                end
                S_DRAIN1:
                begin
                    if (!head_due[1])
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dir_reg <= direction;
            tag_reg <= TAG_WIDTH'(packet_tag);
            all_reg <= (action == ACT_FLUSH);
        end
        if (div_done)
        begin
            key_reg <= key_sum[KEY_W] ? KEY_MAX : key_sum[KEY_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_tag       = out_tag_reg;
    assign out_direction = out_direction_reg;
    assign last_in_run   = last_in_run_reg;

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> !qfull[dir_reg])
        else $error("insert into a full chain");

    a_pop_due_only: assert property (@(posedge clk) disable iff (!rst_n)
        (qop[0].pop || qop[1].pop) |-> out_free && !(qop[0].pop && qop[1].pop))
        else $error("pop without room or from both chains");

    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS && out_free) |=> out_valid_reg && last_in_run_reg)
        else $error("passed item not marked last");

    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg[0] >= $past(cnt_reg[0]) && cnt_reg[1] >= $past(cnt_reg[1]))
        else $error("packet counter went down");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for packet_reorder_holder_core: directed and random items,
// an in-house predictor of the held queues, and checks of every output item.
// Depends on prh_pkg and the packet_reorder_holder_core RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import prh_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic                dir;
        logic [TAG_IN_W-1:0] tag;
        logic                hold;
        logic [RND_W-1:0]    rnd;
    } pkt_item_t;

    typedef struct packed {
        logic [TAG_IN_W-1:0] tag;
        logic                dir;
        logic                last;
    } pkt_out_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACT_W-1:0] action = '0;
    logic direction = 1'b0;
    logic [TAG_IN_W-1:0] packet_tag = '0;
    logic hold = 1'b0;
    logic [RND_W-1:0] random_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TAG_IN_W-1:0] out_tag;
    logic out_direction;
    logic last_in_run;
    logic cfg_we;
    logic [DIS_W-1:0] cfg_data;

    packet_reorder_holder_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .direction(direction), .packet_tag(packet_tag),
        .hold(hold), .random_value(random_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_tag(out_tag), .out_direction(out_direction), .last_in_run(last_in_run),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // predictor state
    logic [KEY_W-1:0]    pkt_count [2];
    logic [KEY_W-1:0]    slot_key [2*DEPTH];
    logic [TAG_IN_W-1:0] slot_tag [2*DEPTH];
    logic                slot_used [2*DEPTH];
    int                  slot_age [2*DEPTH];
    logic [DIS_W-1:0]    disorder;

    pkt_item_t pending_items[$];
    pkt_out_t  expected_pkts[$];
    int        fail_count = 0;
    bit        in_taken = 1'b0;
    bit        out_taken = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_drain(input int d, input bit all);
        int best;
        logic [KEY_W-1:0] bkey;
        int s;
        forever
        begin
            best = -1;
            bkey = '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                s = d*DEPTH + i;
                if (slot_used[s] && (best < 0 || slot_key[s] < bkey ||
                    (slot_key[s] == bkey && slot_age[s] < slot_age[best])))
                begin
                    best = s;
                    bkey = slot_key[s];
                end
            end
            if (best < 0 || (!all && bkey > pkt_count[d]))
                return;
            expected_pkts.push_back('{tag: slot_tag[best], dir: 1'(d), last: 1'b0});
            slot_used[best] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                s = d*DEPTH + i;
                if (slot_used[s] && slot_age[s] > slot_age[best])
                    slot_age[s]--;
            end
        end
    endtask

    task automatic predict_item(input pkt_item_t it);
        int d;
        int n;
        int before_cnt;
        logic [KEY_W:0] key;
        logic [DIS_W-1:0] m;
        pkt_out_t last_pkt;
        d = it.dir;
        before_cnt = expected_pkts.size();
        if (it.act == ACT_NEW)
        begin
            if (pkt_count[d] != KEY_MAX)
                pkt_count[d]++;
            n = 0;
            for (int i = 0; i < DEPTH; i++)
                if (slot_used[d*DEPTH+i])
                    n++;
            if (it.hold && n < DEPTH)
            begin
                m = (disorder == '0) ? DIS_W'(1) : disorder;
                key = {1'b0, pkt_count[d]} + (KEY_W + 1)'(it.rnd % m) + (KEY_W + 1)'(1);
                if (key > {1'b0, KEY_MAX})
                    key = {1'b0, KEY_MAX};
                for (int i = 0; i < DEPTH; i++)
                    if (!slot_used[d*DEPTH+i])
                    begin
                        slot_used[d*DEPTH+i] = 1'b1;
                        slot_key[d*DEPTH+i] = key[KEY_W-1:0];
                        slot_tag[d*DEPTH+i] = it.tag;
                        slot_age[d*DEPTH+i] = n;
                        return;
                    end
            end
            expected_pkts.push_back('{tag: it.tag, dir: it.dir, last: 1'b1});
            return;
        end
        else if (it.act == ACT_RELEASE || it.act == ACT_FLUSH)
        begin
            predict_drain(0, it.act == ACT_FLUSH);
            predict_drain(1, it.act == ACT_FLUSH);
        end
        if (expected_pkts.size() > before_cnt)
        begin
            last_pkt = expected_pkts.pop_back();
            last_pkt.last = 1'b1;
            expected_pkts.push_back(last_pkt);
        end
    endtask

    // driver
    int in_gap = 0;
    pkt_item_t cur_item;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pkt_count[0] = '0;
            pkt_count[1] = '0;
            for (int i = 0; i < 2*DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i] = '0;
                slot_tag[i] = '0;
                slot_age[i] = 0;
            end
        end
        else
        begin
            if (in_taken)
            begin
                predict_item(cur_item);
                void'(pending_items.pop_front());
                in_gap = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0)
                    in_gap = 0;
            end
            if (!in_valid || in_taken)
            begin
                if (in_gap > 0 || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
                else
                begin
                    cur_item = pending_items[0];
                    in_valid <= 1'b1;
                    action <= cur_item.act;
                    direction <= cur_item.dir;
                    packet_tag <= cur_item.tag;
                    hold <= cur_item.hold;
                    random_value <= cur_item.rnd;
                end
            end
        end
    end

    // monitor
    int out_gap = 0;
    pkt_out_t exp_pkt;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pkts.size() == 0)
            begin
                $error("unexpected item: tag %h dir %b", out_tag, out_direction);
                fail_count++;
            end
            else
            begin
                exp_pkt = expected_pkts.pop_front();
                if (out_tag !== exp_pkt.tag)
                begin
                    $error("out_tag expected %h actual %h", exp_pkt.tag, out_tag);
                    fail_count++;
                end
                if (out_direction !== exp_pkt.dir)
                begin
                    $error("out_direction expected %b actual %b", exp_pkt.dir,
                        out_direction);
                    fail_count++;
                end
                if (last_in_run !== exp_pkt.last)
                begin
                    $error("last_in_run expected %b actual %b", exp_pkt.last,
                        last_in_run);
                    fail_count++;
                end
            end
        end
        in_taken <= rst_n && in_valid && !in_stall;
        out_taken <= rst_n && out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if (out_taken)
            out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic pkt_item_t mk(input int a, input int d, input int t, input int h,
        input int r);
        pkt_item_t it;
        it.act = ACT_W'(a);
        it.dir = 1'(d);
        it.tag = TAG_IN_W'(t);
        it.hold = 1'(h);
        it.rnd = RND_W'(r);
        return it;
    endfunction

    function automatic pkt_item_t rand_item(input bit well_formed);
        pkt_item_t it;
        int r;
        it = mk(ACT_NEW, $urandom_range(0, 1), $urandom_range(0, 65535),
            $urandom_range(0, 3) != 0, $urandom_range(0, 65535));
        if (!well_formed)
            it.act = ACT_W'($urandom_range(0, 3));
        else
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                it.act = ACT_RELEASE;
            else if (r == 1 && $urandom_range(0, 2) == 0)
                it.act = ACT_FLUSH;
        end
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_pkts.size() != 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_disorder(input logic [DIS_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        disorder = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [DIS_W-1:0] settings [5];
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        disorder = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        pending_items.push_back(mk(ACT_NEW, 0, 16'h0000, 0, 0));
        pending_items.push_back(mk(ACT_NEW, 1, 16'hFFFF, 0, 16'hFFFF));
        pending_items.push_back(mk(ACT_NEW, 0, 16'h1234, 1, 16'hFFFF));
        pending_items.push_back(mk(ACT_NEW, 0, 16'h5678, 1, 0));
        pending_items.push_back(mk(ACT_NEW, 1, 16'hAAAA, 1, 16'h5555));
        pending_items.push_back(mk(ACT_UNUSED, 1, 16'hBEEF, 1, 7));
        pending_items.push_back(mk(ACT_RELEASE, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_RELEASE, 1, 0, 0, 0));
        pending_items.push_back(mk(ACT_FLUSH, 0, 0, 0, 0));
        pending_items.push_back(mk(ACT_FLUSH, 1, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            pending_items.push_back(mk(ACT_NEW, 1, 16'h0100 + i, 1, i));
        pending_items.push_back(mk(ACT_FLUSH, 0, 0, 0, 0));
        wait_idle();

        settings = '{16'd0, 16'hFFFF, 16'd3, 16'd1, 16'd7};
        foreach (settings[p])
        begin
            write_disorder(settings[p]);
            for (int i = 0; i < 15; i++)
                pending_items.push_back(rand_item($urandom_range(0, 5) != 0));
            pending_items.push_back(mk(ACT_FLUSH, 0, 0, 0, 0));
            wait_idle();
        end
        if (fail_count == 0)
            $display("packet_reorder_holder_core regression: pass");
        else
            $display("packet_reorder_holder_core regression: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("packet_reorder_holder_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== packet_reorder_holder_core.f =====
rtl/prh_pkg.sv
rtl/prh_cell.sv
rtl/prh_queue.sv
rtl/prh_modu.sv
rtl/packet_reorder_holder_core.sv
tb/testbench.sv
